@@ rtl/nmcu_pkg.sv @@
// Package for the neuron MAC block: payload types, store control and fixed-point constants.
`timescale 1ns / 1ps

package nmcu_pkg;

    // Operation codes carried in the input transaction
    localparam logic [1:0] OP_WRITE_WEIGHT = 2'd0;
    localparam logic [1:0] OP_WRITE_BIAS   = 2'd1;
    localparam logic [1:0] OP_FORWARD      = 2'd2;
    localparam logic [1:0] OP_UPDATE       = 2'd3;

    // Field widths
    localparam int INDEX_W = 8;
    localparam int Q_W     = 16;
    localparam int LR_W    = 15;
    localparam int ACC_W   = 40;
    localparam int OUT_W   = 32;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Learning rate after reset (about 0.01 in Q4.12)
    localparam logic [LR_W-1:0] LR_RESET = 15'd41;

    // One in Q4.12, the clamp bound of weights and bias
    localparam int Q_ONE = 4096;

    typedef struct packed {
        logic [1:0]            operation;
        logic [INDEX_W-1:0]    index;
        logic signed [Q_W-1:0] value;
        logic signed [Q_W-1:0] slope;
        logic                  last;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] pre_activation;
        logic                    saturated;
    } out_t;

    // Weight store port control: reads and writes never share a cycle
    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [INDEX_W-1:0] addr;
    } mem_ctl_t;

    // Clamp a wide signed value to [-1, 1] in Q4.12
    function automatic logic signed [Q_W-1:0] clamp_unit(input logic signed [39:0] x);
        logic signed [Q_W-1:0] r;
        if (x > 40'sd4096) begin
            r = Q_W'(Q_ONE);
        end else if (x < -40'sd4096) begin
            r = -Q_W'(Q_ONE);
        end else begin
            r = x[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/nmcu_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module nmcu_mul
    import nmcu_pkg::*;
(
    input  logic                      aclk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] p
);

    logic signed [MUL_P_W-1:0] p_reg;

    // Product register, loaded every cycle; the sequencer picks when to use it
    always_ff @(posedge aclk) begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

@@ rtl/nmcu_wstore.sv @@
// Single-port weight memory with registered read data.
`timescale 1ns / 1ps

module nmcu_wstore
    import nmcu_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                  aclk,
    input  mem_ctl_t              ctl,
    input  logic signed [Q_W-1:0] wr_data,
    output logic signed [Q_W-1:0] rd_data
);

    logic signed [Q_W-1:0] store_reg [DEPTH];
    logic signed [Q_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]     addr;

    assign addr = ctl.addr[ADDR_W-1:0];

    // Write port
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            store_reg[addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= store_reg[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/neuron_mac_clamped_update.sv @@
// Top level: neuron weight store, bias, MAC forward pass and clamped update sequencer.
`timescale 1ns / 1ps
//
// Usage: s_valid/s_ready carries one transaction per item (operation, index,
// value, slope, last). Weight and bias loads use a load step. Forward elements
// use fetch, multiply and accumulate steps; the element marked last adds a
// total step that loads the pre-activation sum into the m_ payload register,
// visible on m_valid the cycle after. Update elements use fetch, multiply and
// weight update steps, plus a bias step when last. Products pass through the
// shared multiplier's output register; the weight read is registered before
// the first multiply. s_ready is high only while the sequencer is idle.
// cfg_wr_en/cfg_wr_data write the learning rate; write only while idle.
// A result waiting on m_ready does not block loads or updates; a following
// final forward element holds in its output step until the result is taken.
// Reset (aresetn low, synchronous) clears the sequencer, accumulator, bias,
// saturation flag and output valid, and sets the learning rate to 41. Weights
// are undefined until written; no clearing pass is done.
//
module neuron_mac_clamped_update
    import nmcu_pkg::*;
#(
    parameter int MAX_INPUTS = 256
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  in_t             s_payload,
    output logic            m_valid,
    input  logic            m_ready,
    output out_t            m_payload,
    input  logic            cfg_wr_en,
    input  logic [LR_W-1:0] cfg_wr_data
);

    localparam int STORE_DEPTH = (MAX_INPUTS < 256) ? MAX_INPUTS : 256;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_TOTAL = 3'd5;
    localparam logic [2:0] S_WUPD  = 3'd6;
    localparam logic [2:0] S_BUPD  = 3'd7;

    logic [2:0]              state_reg, state_next;
    in_t                     item_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    clip_reg, clip_next;
    logic signed [Q_W-1:0]   bias_reg, bias_next;
    logic [LR_W-1:0]         lr_reg;
    logic                    m_valid_reg, m_valid_next;
    out_t                    out_reg, out_next;

    mem_ctl_t                  mem_ctl;
    logic signed [Q_W-1:0]     mem_wr_data;
    logic signed [Q_W-1:0]     weight;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic                    idx_in_range;
    logic                    accept;
    logic                    out_free;
    logic signed [MUL_B_W-1:0] lr_op;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W+1:0] total_raw;
    logic signed [ACC_W+1:0] total_shr;
    logic signed [MUL_P_W-1:0] w_rnd;
    logic signed [MUL_P_W-1:0] b_rnd;
    logic signed [39:0]      w_new;
    logic signed [39:0]      b_new;

    assign accept       = s_valid && s_ready;
    assign s_ready      = (state_reg == S_IDLE);
    assign out_free     = !m_valid_reg || m_ready;
    assign idx_in_range = (32'(item_reg.index) < 32'(MAX_INPUTS));
    assign lr_op        = $signed({1'b0, lr_reg});

    nmcu_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    nmcu_wstore #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_wstore (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .wr_data (mem_wr_data),
        .rd_data (weight)
    );

    // Saturating accumulate of value*weight; out-of-range index adds nothing
    always_comb begin
        logic signed [ACC_W:0] addend;
        addend  = idx_in_range ? (ACC_W+1)'($signed(mul_p[31:0])) : '0;
        acc_sum = (ACC_W+1)'(acc_reg) + addend;
    end

    // Bias plus sum, rounded half up to Q20.12
    assign total_raw = (ACC_W+2)'(acc_reg) + ((ACC_W+2)'(bias_reg) <<< 12)
                     + (ACC_W+2)'(2048);
    assign total_shr = total_raw >>> 12;

    // Weight step: round the Q12.36 product to Q4.12, subtract, clamp later
    assign w_rnd = mul_p + MUL_P_W'(64'sd8388608);
    assign w_new = 40'(weight) - 40'(w_rnd >>> 24);

    // Bias step: round the Q8.24 product to Q4.12
    assign b_rnd = mul_p + MUL_P_W'(64'sd2048);
    assign b_new = 40'(bias_reg) - 40'(b_rnd >>> 12);

    // Sequencer and datapath control
    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        clip_next    = clip_reg;
        bias_next    = bias_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        mem_ctl      = '{wr_en: 1'b0, rd_en: 1'b0, addr: item_reg.index};
        mem_wr_data  = item_reg.value;
        mul_a        = MUL_A_W'(item_reg.value);
        mul_b        = item_reg.slope;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_payload.operation == OP_WRITE_WEIGHT ||
                        s_payload.operation == OP_WRITE_BIAS) begin
                        state_next = S_LOAD;
                    end else begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_LOAD: begin
                if (item_reg.operation == OP_WRITE_WEIGHT) begin
                    mem_ctl.wr_en = idx_in_range;
                end else begin
                    bias_next = item_reg.value;
                end
                state_next = S_IDLE;
            end
            S_FETCH: begin
                // weight read; value*slope starts for updates
                mem_ctl.rd_en = 1'b1;
                state_next    = S_MUL1;
            end
            S_MUL1: begin
                if (item_reg.operation == OP_FORWARD) begin
                    mul_b      = weight;
                    state_next = S_ACC;
                end else begin
                    mul_a      = mul_p[MUL_A_W-1:0];
                    mul_b      = lr_op;
                    state_next = S_WUPD;
                end
            end
            S_ACC: begin
                if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
                    acc_next  = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                               : {1'b0, {(ACC_W-1){1'b1}}};
                    clip_next = 1'b1;
                end else begin
                    acc_next = acc_sum[ACC_W-1:0];
                end
                state_next = item_reg.last ? S_TOTAL : S_IDLE;
            end
            S_TOTAL: begin
                if (out_free) begin
                    if (total_shr > (ACC_W+2)'(64'sd2147483647)) begin
                        out_next.pre_activation = {1'b0, {(OUT_W-1){1'b1}}};
                        out_next.saturated      = 1'b1;
                    end else if (total_shr < (ACC_W+2)'(-64'sd2147483648)) begin
                        out_next.pre_activation = {1'b1, {(OUT_W-1){1'b0}}};
                        out_next.saturated      = 1'b1;
                    end else begin
                        out_next.pre_activation = total_shr[OUT_W-1:0];
                        out_next.saturated      = clip_reg;
                    end
                    m_valid_next = 1'b1;
                    acc_next     = '0;
                    clip_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            S_WUPD: begin
                mem_wr_data   = clamp_unit(w_new);
                mem_ctl.wr_en = idx_in_range;
                // slope*rate for the bias step
                mul_a         = MUL_A_W'(item_reg.slope);
                mul_b         = lr_op;
                state_next    = item_reg.last ? S_BUPD : S_IDLE;
            end
            S_BUPD: begin
                bias_next  = clamp_unit(b_new);
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            acc_reg     <= '0;
            clip_reg    <= 1'b0;
            bias_reg    <= '0;
            m_valid_reg <= 1'b0;
            lr_reg      <= LR_RESET;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            clip_reg    <= clip_next;
            bias_reg    <= bias_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                lr_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_payload;
        end
        out_reg <= out_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

`ifndef SYNTHESIS
    // Loads go straight to the load step
    a_load_path: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_payload.operation == OP_WRITE_WEIGHT ||
                   s_payload.operation == OP_WRITE_BIAS) |=> state_reg == S_LOAD)
        else $error("load transaction did not enter load step");

    // Store writes only from the load or weight update step
    a_store_write: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_ctl.wr_en |-> (state_reg == S_LOAD || state_reg == S_WUPD))
        else $error("weight store written outside load or update");

    // Emitting a result clears the pass state and raises valid
    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_TOTAL && out_free |=> m_valid_reg && acc_reg == '0 && !clip_reg)
        else $error("result emitted without clearing accumulator");

    // Bias stays inside [-1, 1] after its update step
    a_bias_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_BUPD |=> (bias_reg <= 16'sd4096 && bias_reg >= -16'sd4096))
        else $error("bias outside clamp range after update");
`endif

endmodule

@@ tb/neuron_mac_clamped_update_tb.sv @@
// Testbench for neuron_mac_clamped_update: shadow model, scoreboard and valid/ready stimulus.
`timescale 1ns / 1ps

module neuron_mac_clamped_update_tb;
    import nmcu_pkg::*;

    localparam longint ACC_HI       = 64'sd549755813887;
    localparam longint ACC_LO       = -ACC_HI - 1;
    localparam longint OUT_HI       = 64'sd2147483647;
    localparam longint OUT_LO       = -64'sd2147483648;
    localparam int     IDLE_SETTLE  = 8;
    localparam int     END_CYCLES   = 12;
    localparam int     WATCHDOG_MAX = 2000;

    // Shadow copy of the neuron state; predicts each pre-activation sum
    class preact_scoreboard;
        logic signed [Q_W-1:0] weights [256];
        logic signed [Q_W-1:0] bias;
        longint                acc;
        bit                    clip;
        logic [LR_W-1:0]       rate;
        out_t                  expected_sums [$];
        int                    errors;

        function new();
            foreach (weights[i]) weights[i] = '0;
            bias   = '0;
            acc    = 0;
            clip   = 1'b0;
            rate   = 15'd41;
            errors = 0;
        endfunction

        function void set_rate(logic [LR_W-1:0] r);
            rate = r;
        endfunction

        // add 2^(s-1), then floor
        function longint round_half_up(longint x, int s);
            return (x + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function logic signed [Q_W-1:0] limit_unit(longint x);
            if (x > 4096) begin
                return 16'sd4096;
            end else if (x < -4096) begin
                return -16'sd4096;
            end
            return x[Q_W-1:0];
        endfunction

        // Every index fits the default store depth, so no range check
        function void apply_item(in_t item);
            longint v, sl, w, sum, total, step;
            bit     sat;
            out_t   sum_out;
            v  = longint'($signed(item.value));
            sl = longint'($signed(item.slope));
            case (item.operation)
                OP_WRITE_WEIGHT: begin
                    weights[item.index] = item.value;
                end
                OP_WRITE_BIAS: begin
                    bias = item.value;
                end
                OP_FORWARD: begin
                    w   = longint'(weights[item.index]);
                    sum = acc + v * w;
                    if (sum > ACC_HI) begin
                        sum  = ACC_HI;
                        clip = 1'b1;
                    end else if (sum < ACC_LO) begin
                        sum  = ACC_LO;
                        clip = 1'b1;
                    end
                    acc = sum;
                    if (item.last) begin
                        total = round_half_up(acc + longint'(bias) * 4096, 12);
                        sat   = clip;
                        if (total > OUT_HI) begin
                            total = OUT_HI;
                            sat   = 1'b1;
                        end else if (total < OUT_LO) begin
                            total = OUT_LO;
                            sat   = 1'b1;
                        end
                        sum_out.pre_activation = total[OUT_W-1:0];
                        sum_out.saturated      = sat;
                        expected_sums.push_back(sum_out);
                        acc  = 0;
                        clip = 1'b0;
                    end
                end
                default: begin
                    // update: weight step, then bias step on the last element
                    step = round_half_up(v * sl * longint'(rate), 24);
                    weights[item.index] = limit_unit(longint'(weights[item.index]) - step);
                    if (item.last) begin
                        step = round_half_up(sl * longint'(rate), 12);
                        bias = limit_unit(longint'(bias) - step);
                    end
                end
            endcase
        endfunction

        function void compare_sum(out_t got);
            out_t want;
            if (expected_sums.size() == 0) begin
                $error("unexpected result: pre_activation %0d saturated %0b",
                       got.pre_activation, got.saturated);
                errors++;
                return;
            end
            want = expected_sums.pop_front();
            if (got.pre_activation !== want.pre_activation) begin
                $error("pre_activation: expected %0d, actual %0d",
                       want.pre_activation, got.pre_activation);
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic            aclk        = 1'b0;
    logic            aresetn     = 1'b0;
    logic            s_valid     = 1'b0;
    logic            s_ready;
    in_t             s_payload   = '0;
    logic            m_valid;
    logic            m_ready     = 1'b0;
    out_t            m_payload;
    logic            cfg_wr_en   = 1'b0;
    logic [LR_W-1:0] cfg_wr_data = '0;

    preact_scoreboard sb;
    bit               allow_idle = 1'b1;
    int               sent_count = 0;
    int               stall_cycles = 0;
    bit               is_loaded [256];
    int               loaded_idx [$];

    neuron_mac_clamped_update dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Result side: random back-pressure bursts
    initial begin
        forever begin
            @(posedge aclk);
            if (allow_idle && m_ready && $urandom_range(0, 99) < 20) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Check every result transaction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.compare_sum(m_payload);
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_MAX) begin
            $display("neuron_mac_clamped_update test failed");
            $finish;
        end
    end

    function automatic in_t build_item(logic [1:0] op, int idx, logic signed [Q_W-1:0] val,
                                       logic signed [Q_W-1:0] slp, bit fin);
        in_t it;
        it.operation = op;
        it.index     = INDEX_W'(idx);
        it.value     = val;
        it.slope     = slp;
        it.last      = fin;
        return it;
    endfunction

    // Q4.12 values, weighted toward the extremes and unit bounds
    function automatic logic signed [Q_W-1:0] rand_q16();
        case ($urandom_range(0, 11))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh1000;
            3:       return 16'shF000;
            4:       return 16'sh0000;
            5:       return 16'shFFFF;
            default: return Q_W'($urandom);
        endcase
    endfunction

    function automatic int pick_loaded();
        return loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
    endfunction

    // One input transaction; an optional gap ahead of it
    task automatic send_item(input in_t item);
        if (allow_idle && $urandom_range(0, 99) < 15) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
        sb.apply_item(item);
        sent_count++;
    endtask

    task automatic load_weight(input int idx, input logic signed [Q_W-1:0] val);
        send_item(build_item(OP_WRITE_WEIGHT, idx, val, rand_q16(), 1'($urandom_range(0, 1))));
        if (!is_loaded[idx]) begin
            is_loaded[idx] = 1'b1;
            loaded_idx.push_back(idx);
        end
    endtask

    task automatic forward_pass(input int len);
        for (int k = 0; k < len; k++) begin
            send_item(build_item(OP_FORWARD, pick_loaded(), rand_q16(), rand_q16(), k == len - 1));
        end
    endtask

    task automatic update_pass(input int len);
        for (int k = 0; k < len; k++) begin
            send_item(build_item(OP_UPDATE, pick_loaded(), rand_q16(), rand_q16(), k == len - 1));
        end
    endtask

    // Let every result drain and the sequencer go idle, then write the rate
    task automatic settle_and_set_rate(input logic [LR_W-1:0] r);
        s_valid <= 1'b0;
        while (sb.expected_sums.size() != 0) @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_rate(r);
    endtask

    task automatic random_traffic(input int n);
        int   start;
        int   pick;
        in_t  it;
        start = sent_count;
        while (sent_count - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                forward_pass($urandom_range(1, 8));
            end else if (pick < 62) begin
                update_pass($urandom_range(1, 6));
            end else if (pick < 77) begin
                repeat ($urandom_range(1, 4)) load_weight($urandom_range(0, 255), rand_q16());
            end else if (pick < 83) begin
                send_item(build_item(OP_WRITE_BIAS, $urandom_range(0, 255), rand_q16(),
                                     rand_q16(), 1'($urandom_range(0, 1))));
            end else begin
                // noise: any operation, but never a read of an unwritten weight
                it = build_item(2'($urandom_range(0, 3)), $urandom_range(0, 255), rand_q16(),
                                rand_q16(), 1'($urandom_range(0, 1)));
                if ((it.operation == OP_FORWARD || it.operation == OP_UPDATE) &&
                    !is_loaded[it.index]) begin
                    it.index = INDEX_W'(pick_loaded());
                end
                send_item(it);
                if (it.operation == OP_WRITE_WEIGHT && !is_loaded[it.index]) begin
                    is_loaded[it.index] = 1'b1;
                    loaded_idx.push_back(int'(it.index));
                end
            end
        end
    endtask

    initial begin
        sb = new();
        foreach (is_loaded[i]) is_loaded[i] = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: unclamped loads at the extremes, last on loads, both passes
        load_weight(0, 16'sh7FFF);
        load_weight(255, 16'sh8000);
        load_weight(8'hAA, 16'sh1000);
        load_weight(8'h55, 16'shF000);
        send_item(build_item(OP_WRITE_BIAS, 8'h3C, 16'sh7FFF, 16'sh8000, 1'b1));
        send_item(build_item(OP_FORWARD, 0, 16'sh7FFF, 16'sh0000, 1'b0));
        send_item(build_item(OP_FORWARD, 255, 16'sh8000, 16'sh7FFF, 1'b0));
        send_item(build_item(OP_FORWARD, 8'hAA, 16'shFFFF, 16'sh8000, 1'b0));
        send_item(build_item(OP_FORWARD, 8'h55, 16'sh0000, 16'shFFFF, 1'b1));
        send_item(build_item(OP_FORWARD, 255, 16'sh7FFF, 16'sh0000, 1'b1));
        // updates that clamp the weights and the bias to the unit bounds
        send_item(build_item(OP_UPDATE, 0, 16'sh7FFF, 16'sh7FFF, 1'b0));
        send_item(build_item(OP_UPDATE, 255, 16'sh8000, 16'sh7FFF, 1'b1));
        send_item(build_item(OP_UPDATE, 8'hAA, 16'sh8000, 16'sh8000, 1'b1));
        send_item(build_item(OP_FORWARD, 0, 16'sh1000, 16'sh1234, 1'b0));
        send_item(build_item(OP_FORWARD, 255, 16'sh8000, 16'sh0000, 1'b0));
        send_item(build_item(OP_FORWARD, 8'hAA, 16'sh7FFF, 16'sh0000, 1'b0));
        send_item(build_item(OP_FORWARD, 8'h55, 16'sh8000, 16'sh0000, 1'b1));
        send_item(build_item(OP_WRITE_BIAS, 8'hC3, 16'sh8000, 16'sh0000, 1'b0));
        send_item(build_item(OP_FORWARD, 8'h55, 16'sh0000, 16'sh0000, 1'b1));

        // Largest rate
        settle_and_set_rate(15'h7FFF);
        random_traffic(85);

        settle_and_set_rate(15'h0000);
        random_traffic(85);

        settle_and_set_rate(LR_W'($urandom_range(2, 32766)));
        random_traffic(85);

        settle_and_set_rate(15'd1);
        random_traffic(85);

        // Last part: back to the reset rate, no idling on either side
        settle_and_set_rate(LR_RESET);
        allow_idle = 1'b0;
        random_traffic(85);

        s_valid <= 1'b0;
        while (sb.expected_sums.size() != 0) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("neuron_mac_clamped_update test passed");
        end else begin
            $display("neuron_mac_clamped_update test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/nmcu_pkg.sv
rtl/nmcu_mul.sv
rtl/nmcu_wstore.sv
rtl/neuron_mac_clamped_update.sv
tb/neuron_mac_clamped_update_tb.sv
